>>> hw/rtl/shr_pkg.sv
package shr_pkg;

  // Ring geometry
  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Field widths
  localparam int ACTION_W   = 3;
  localparam int HANDLE_W   = 32;
  localparam int BYTES_W    = 24;
  localparam int TOTAL_W    = 28;
  localparam int INTERVAL_W = 16;
  localparam int LIMIT_W    = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT    = 1'd1;
  localparam logic [INTERVAL_W-1:0]  INTERVAL_RESET = 16'd60;
  localparam logic [LIMIT_W-1:0]     LIMIT_RESET    = 8'd3;

  // Action codes on the request channel
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CAPTURE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REWIND  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RESTORE = 3'd4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_TICK,
    OP_CAPTURE,
    OP_CAPTURE_FAIL,
    OP_REWIND,
    OP_RESTORE
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [HANDLE_W-1:0] handle;
    logic [BYTES_W-1:0]  bytes;
    logic                restore_ok;
  } req_t;

  typedef struct packed {
    logic                capture_request;
    logic                accepted;
    logic                release_valid;
    logic [HANDLE_W-1:0] release_handle;
    logic                restore_valid;
    logic [HANDLE_W-1:0] restore_handle;
    logic [CNT_W-1:0]    entries_held;
    logic [TOTAL_W-1:0]  bytes_held;
    logic                disabled;
    logic                last;
  } rsp_t;

  typedef enum logic [0:0] {
    BK_RUN,
    BK_WALK
  } back_state_t;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(SLOTS - 1)) ? '0 : IDX_W'(i + 1'b1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(SLOTS - 1) : IDX_W'(i - 1'b1);
  endfunction

endpackage

>>> hw/rtl/shr_req_if.sv
interface shr_req_if;
  logic                            valid;
  logic                            ready;
  logic [shr_pkg::ACTION_W-1:0]    action;
  logic [shr_pkg::HANDLE_W-1:0]    handle;
  logic [shr_pkg::BYTES_W-1:0]     snapshot_bytes;
  logic                            restore_ok;

  modport source (output valid, action, handle, snapshot_bytes, restore_ok, input ready);
  modport sink   (input valid, action, handle, snapshot_bytes, restore_ok, output ready);
endinterface

>>> hw/rtl/shr_rsp_if.sv
interface shr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         capture_request;
  logic                         accepted;
  logic                         release_valid;
  logic [shr_pkg::HANDLE_W-1:0] release_handle;
  logic                         restore_valid;
  logic [shr_pkg::HANDLE_W-1:0] restore_handle;
  logic [shr_pkg::CNT_W-1:0]    entries_held;
  logic [shr_pkg::TOTAL_W-1:0]  bytes_held;
  logic                         disabled;
  logic                         last;

  modport source (output valid, capture_request, accepted, release_valid, release_handle,
                  restore_valid, restore_handle, entries_held, bytes_held, disabled, last,
                  input ready);
  modport sink   (input valid, capture_request, accepted, release_valid, release_handle,
                  restore_valid, restore_handle, entries_held, bytes_held, disabled, last,
                  output ready);
endinterface

>>> hw/rtl/snapshot_history_ring.sv
// Snapshot history ring: keeps up to 16 snapshot handles with their byte sizes and tells
// software when to capture, what to restore and what to free. Each request on item gives
// one result on result, except clear, which gives one result per released handle (newest
// first) or a single empty result when nothing was held; last marks the final result of a
// request. A request passes a two-entry queue, then the back end runs it into the result
// register; while result is drained every cycle and no clear walk is running, the block
// sustains one request per cycle. Clear walks the ring one slot per cycle while the result
// side keeps up, and holds the back end until the walk and its final result are out, during
// which no further request leaves the queue. No clearing pass runs after reset. Write the
// capture interval (index 0) and failure_limit (index 1) only while the block is idle; a
// value of zero acts as one.
module snapshot_history_ring (
  input  logic                            clk,
  input  logic                            rst,
  shr_req_if.sink                         item,
  shr_rsp_if.source                       result,
  input  logic                            cfg_we,
  input  logic [shr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [shr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Classified requests waiting for the back end
  logic          q_valid;
  logic          q_ready;
  shr_pkg::req_t q_data;

  // Front: take requests, decode the action, hold them in the queue
  shr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_ready (q_ready)
  );

  // Back: own the ring and counters, run each request, drive the result register
  shr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_ready   (q_ready),
    .result    (result)
  );

endmodule

>>> hw/rtl/shr_front.sv
module shr_front (
  input  logic          clk,
  input  logic          rst,
  shr_req_if.sink       item,
  output logic          q_valid,
  output shr_pkg::req_t q_data,
  input  logic          q_ready
);

  shr_pkg::req_t                  q_mem [shr_pkg::QUEUE_DEPTH];
  logic [shr_pkg::QPTR_W-1:0]     wr_ptr;
  logic [shr_pkg::QPTR_W-1:0]     rd_ptr;
  logic [shr_pkg::QCNT_W-1:0]     q_count;
  shr_pkg::req_t                  classified;
  logic                           push;
  logic                           pop;

  // Decode the action into an operation the back end can run directly
  always_comb begin
    classified.handle     = item.handle;
    classified.bytes      = item.snapshot_bytes;
    classified.restore_ok = item.restore_ok;
    unique case (item.action)
      shr_pkg::ACT_CLEAR:   classified.op = shr_pkg::OP_CLEAR;
      shr_pkg::ACT_TICK:    classified.op = shr_pkg::OP_TICK;
      shr_pkg::ACT_CAPTURE: classified.op = (item.handle == '0) ? shr_pkg::OP_CAPTURE_FAIL
                                                                : shr_pkg::OP_CAPTURE;
      shr_pkg::ACT_REWIND:  classified.op = shr_pkg::OP_REWIND;
      shr_pkg::ACT_RESTORE: classified.op = shr_pkg::OP_RESTORE;
      default:              classified.op = shr_pkg::OP_NONE;
    endcase
  end

  assign item.ready = (q_count != shr_pkg::QCNT_W'(shr_pkg::QUEUE_DEPTH));
  assign push       = item.valid && item.ready;
  assign q_valid    = (q_count != '0);
  assign q_data     = q_mem[rd_ptr];
  assign pop        = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == shr_pkg::QPTR_W'(shr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == shr_pkg::QPTR_W'(shr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        q_count <= q_count + 1'b1;
      end else if (pop && !push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/shr_back.sv
module shr_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [shr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [shr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             q_valid,
  input  shr_pkg::req_t                    q_data,
  output logic                             q_ready,
  shr_rsp_if.source                        result
);

  // Ring storage
  logic [shr_pkg::HANDLE_W-1:0]   slot_handle [shr_pkg::SLOTS];
  logic [shr_pkg::BYTES_W-1:0]    slot_bytes  [shr_pkg::SLOTS];
  logic [shr_pkg::SLOTS-1:0]      slot_full, slot_full_next;

  // Control state
  logic [shr_pkg::IDX_W-1:0]      head, head_next;
  logic [shr_pkg::CNT_W-1:0]      entry_count, entry_count_next;
  logic [shr_pkg::INTERVAL_W-1:0] frame_ctr, frame_ctr_next;
  logic [shr_pkg::LIMIT_W-1:0]    fail_ctr, fail_ctr_next;
  logic                           disabled_flag, disabled_flag_next;
  logic [shr_pkg::TOTAL_W-1:0]    byte_total, byte_total_next;
  logic [shr_pkg::HANDLE_W-1:0]   pending_restore, pending_restore_next;
  logic [shr_pkg::INTERVAL_W-1:0] interval_reg;
  logic [shr_pkg::LIMIT_W-1:0]    limit_reg;

  // Clear walk
  shr_pkg::back_state_t           state, state_next;
  logic [shr_pkg::IDX_W-1:0]      walk_idx, walk_idx_next;
  logic [shr_pkg::CNT_W-1:0]      walk_left, walk_left_next;
  logic                           held_valid, held_valid_next;
  logic [shr_pkg::HANDLE_W-1:0]   held_handle, held_handle_next;

  // Output register
  logic                           out_valid;
  shr_pkg::rsp_t                  out_data;
  logic                           out_free;
  logic                           emit;
  shr_pkg::rsp_t                  emit_data;

  // Datapath helpers
  logic                           take;
  logic [shr_pkg::IDX_W-1:0]      rd_idx;
  logic [shr_pkg::HANDLE_W-1:0]   rd_handle;
  logic [shr_pkg::BYTES_W-1:0]    rd_bytes;
  logic                           rd_full;
  logic                           wr_en;
  logic [shr_pkg::INTERVAL_W-1:0] interval_eff;
  logic [shr_pkg::LIMIT_W-1:0]    limit_eff;
  logic [shr_pkg::INTERVAL_W-1:0] frame_inc;
  logic [shr_pkg::LIMIT_W-1:0]    fail_inc;

  assign out_free     = !out_valid || result.ready;
  assign q_ready      = (state == shr_pkg::BK_RUN) && out_free;
  assign take         = q_valid && q_ready;
  assign interval_eff = (interval_reg == '0) ? shr_pkg::INTERVAL_W'(1) : interval_reg;
  assign limit_eff    = (limit_reg == '0) ? shr_pkg::LIMIT_W'(1) : limit_reg;
  assign frame_inc    = shr_pkg::INTERVAL_W'(frame_ctr + 1'b1);
  assign fail_inc     = (fail_ctr == '1) ? fail_ctr : shr_pkg::LIMIT_W'(fail_ctr + 1'b1);

  // One slot read a cycle: head on capture, behind head on rewind, walk slot on clear
  always_comb begin
    if (state == shr_pkg::BK_WALK) begin
      rd_idx = walk_idx;
    end else if (q_data.op == shr_pkg::OP_REWIND) begin
      rd_idx = shr_pkg::idx_prev(head);
    end else begin
      rd_idx = head;
    end
  end

  assign rd_handle = slot_handle[rd_idx];
  assign rd_bytes  = slot_bytes[rd_idx];
  assign rd_full   = slot_full[rd_idx];

  always_comb begin
    state_next = state;
    unique case (state)
      shr_pkg::BK_RUN: begin
        if (take && q_data.op == shr_pkg::OP_CLEAR) begin
          state_next = shr_pkg::BK_WALK;
        end
      end
      shr_pkg::BK_WALK: begin
        if (walk_left == '0 && out_free) begin
          state_next = shr_pkg::BK_RUN;
        end
      end
    endcase
  end

  always_comb begin
    slot_full_next       = slot_full;
    head_next            = head;
    entry_count_next     = entry_count;
    frame_ctr_next       = frame_ctr;
    fail_ctr_next        = fail_ctr;
    disabled_flag_next   = disabled_flag;
    byte_total_next      = byte_total;
    pending_restore_next = pending_restore;
    walk_idx_next        = walk_idx;
    walk_left_next       = walk_left;
    held_valid_next      = held_valid;
    held_handle_next     = held_handle;
    wr_en                = 1'b0;
    emit                 = 1'b0;
    emit_data            = '0;
    emit_data.last       = 1'b1;

    unique case (state)
      shr_pkg::BK_RUN: begin
        if (take) begin
          emit = 1'b1;
          unique case (q_data.op)
            shr_pkg::OP_CLEAR: begin
              // Latch the walk, reset the summary state now
              emit               = 1'b0;
              walk_idx_next      = shr_pkg::idx_prev(head);
              walk_left_next     = entry_count;
              held_valid_next    = 1'b0;
              head_next          = '0;
              entry_count_next   = '0;
              frame_ctr_next     = '0;
              fail_ctr_next      = '0;
              disabled_flag_next = 1'b0;
              byte_total_next    = '0;
            end
            shr_pkg::OP_TICK: begin
              if (!disabled_flag) begin
                if (frame_inc >= interval_eff) begin
                  frame_ctr_next            = '0;
                  emit_data.capture_request = 1'b1;
                end else begin
                  frame_ctr_next = frame_inc;
                end
              end
            end
            shr_pkg::OP_CAPTURE_FAIL: begin
              if (!disabled_flag) begin
                fail_ctr_next = fail_inc;
                if (fail_inc >= limit_eff) begin
                  disabled_flag_next = 1'b1;
                end
              end
            end
            shr_pkg::OP_CAPTURE: begin
              if (!disabled_flag) begin
                fail_ctr_next = '0;
                if (rd_full) begin
                  emit_data.release_valid  = 1'b1;
                  emit_data.release_handle = rd_handle;
                end else begin
                  entry_count_next = entry_count + 1'b1;
                end
                byte_total_next = shr_pkg::TOTAL_W'(byte_total
                                  - shr_pkg::TOTAL_W'(rd_full ? rd_bytes : '0)
                                  + shr_pkg::TOTAL_W'(q_data.bytes));
                wr_en                = 1'b1;
                slot_full_next[head] = 1'b1;
                head_next            = shr_pkg::idx_next(head);
                emit_data.accepted   = 1'b1;
              end
            end
            shr_pkg::OP_REWIND: begin
              if (!disabled_flag && entry_count != '0 && pending_restore == '0) begin
                head_next = rd_idx;
                if (rd_full) begin
                  slot_full_next[rd_idx]   = 1'b0;
                  byte_total_next          = shr_pkg::TOTAL_W'(byte_total
                                             - shr_pkg::TOTAL_W'(rd_bytes));
                  entry_count_next         = entry_count - 1'b1;
                  frame_ctr_next           = shr_pkg::INTERVAL_W'(interval_eff - 1'b1);
                  pending_restore_next     = rd_handle;
                  emit_data.accepted       = 1'b1;
                  emit_data.restore_valid  = 1'b1;
                  emit_data.restore_handle = rd_handle;
                end
              end
            end
            shr_pkg::OP_RESTORE: begin
              if (pending_restore != '0) begin
                emit_data.release_valid  = 1'b1;
                emit_data.release_handle = pending_restore;
                pending_restore_next     = '0;
                if (q_data.restore_ok) begin
                  emit_data.accepted = 1'b1;
                end else begin
                  disabled_flag_next = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      shr_pkg::BK_WALK: begin
        if (walk_left != '0) begin
          // Keep one found handle back so the final release can carry last
          if (!rd_full || !held_valid || out_free) begin
            if (rd_full) begin
              if (held_valid) begin
                emit                     = 1'b1;
                emit_data.last           = 1'b0;
                emit_data.release_valid  = 1'b1;
                emit_data.release_handle = held_handle;
              end
              held_valid_next  = 1'b1;
              held_handle_next = rd_handle;
            end
            slot_full_next[walk_idx] = 1'b0;
            walk_idx_next            = shr_pkg::idx_prev(walk_idx);
            walk_left_next           = walk_left - 1'b1;
          end
        end else if (out_free) begin
          emit                     = 1'b1;
          emit_data.release_valid  = held_valid;
          emit_data.release_handle = held_valid ? held_handle : '0;
          held_valid_next          = 1'b0;
        end
      end
    endcase

    emit_data.entries_held = entry_count_next;
    emit_data.bytes_held   = byte_total_next;
    emit_data.disabled     = disabled_flag_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_handle[head] <= q_data.handle;
      slot_bytes[head]  <= q_data.bytes;
    end
    held_handle <= held_handle_next;
    walk_idx    <= walk_idx_next;
    if (out_free && emit) begin
      out_data <= emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= shr_pkg::BK_RUN;
      slot_full       <= '0;
      head            <= '0;
      entry_count     <= '0;
      frame_ctr       <= '0;
      fail_ctr        <= '0;
      disabled_flag   <= 1'b0;
      byte_total      <= '0;
      pending_restore <= '0;
      walk_left       <= '0;
      held_valid      <= 1'b0;
      out_valid       <= 1'b0;
      interval_reg    <= shr_pkg::INTERVAL_RESET;
      limit_reg       <= shr_pkg::LIMIT_RESET;
    end else begin
      state           <= state_next;
      slot_full       <= slot_full_next;
      head            <= head_next;
      entry_count     <= entry_count_next;
      frame_ctr       <= frame_ctr_next;
      fail_ctr        <= fail_ctr_next;
      disabled_flag   <= disabled_flag_next;
      byte_total      <= byte_total_next;
      pending_restore <= pending_restore_next;
      walk_left       <= walk_left_next;
      held_valid      <= held_valid_next;
      if (out_free) begin
        out_valid <= emit;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          shr_pkg::CFG_INTERVAL: interval_reg <= cfg_data[shr_pkg::INTERVAL_W-1:0];
          shr_pkg::CFG_LIMIT:    limit_reg    <= cfg_data[shr_pkg::LIMIT_W-1:0];
        endcase
      end
    end
  end

  assign result.valid           = out_valid;
  assign result.capture_request = out_data.capture_request;
  assign result.accepted        = out_data.accepted;
  assign result.release_valid   = out_data.release_valid;
  assign result.release_handle  = out_data.release_handle;
  assign result.restore_valid   = out_data.restore_valid;
  assign result.restore_handle  = out_data.restore_handle;
  assign result.entries_held    = out_data.entries_held;
  assign result.bytes_held      = out_data.bytes_held;
  assign result.disabled        = out_data.disabled;
  assign result.last            = out_data.last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= shr_pkg::CNT_W'(shr_pkg::SLOTS))
    else $error("entry count exceeds ring size");

  a_count_vs_full: assert property (@(posedge clk) disable iff (rst)
    int'(entry_count) <= $countones(slot_full))
    else $error("entry count exceeds occupied slots");

  a_walk_blocks_queue: assert property (@(posedge clk) disable iff (rst)
    (state == shr_pkg::BK_WALK) |-> !q_ready)
    else $error("queue popped during clear walk");

  a_clear_resets: assert property (@(posedge clk) disable iff (rst)
    (take && q_data.op == shr_pkg::OP_CLEAR) |=>
      (entry_count == '0 && byte_total == '0 && !disabled_flag && head == '0))
    else $error("clear left summary state behind");

endmodule

>>> tb/snapshot_history_ring_tb.sv
module snapshot_history_ring_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [shr_pkg::HANDLE_W-1:0] word_t;

  // Actions 5 to 7 carry no meaning; the block must answer them with a bare status.
  localparam logic [shr_pkg::ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [shr_pkg::ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

  // Length of the long result stall that backs the block up into its request queue.
  localparam int HOLD_CYCLES = 200;
  // Quiet time after the last result before touching a register; covers a full clear walk.
  localparam int SETTLE_CYCLES = shr_pkg::SLOTS + 4;
  localparam int RANDOM_PER_PHASE = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            cfg_we;
  logic [shr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [shr_pkg::CFG_DATA_W-1:0]  cfg_data;

  shr_req_if req_bus ();
  shr_rsp_if rsp_bus ();

  snapshot_history_ring dut (
    .clk       (clk),
    .rst       (rst),
    .item      (req_bus),
    .result    (rsp_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Ring predictor: our own copy of the history state and the two registers.
  // ---------------------------------------------------------------------------
  logic [shr_pkg::HANDLE_W-1:0]   ring_handle [shr_pkg::SLOTS] = '{default: '0};
  logic [shr_pkg::BYTES_W-1:0]    ring_bytes  [shr_pkg::SLOTS] = '{default: '0};
  logic                           ring_full   [shr_pkg::SLOTS] = '{default: 1'b0};
  logic [shr_pkg::IDX_W-1:0]      ring_head    = '0;
  logic [shr_pkg::CNT_W-1:0]      ring_count   = '0;
  logic [shr_pkg::INTERVAL_W-1:0] tick_count   = '0;
  logic [shr_pkg::LIMIT_W-1:0]    fail_count   = '0;
  logic                           history_off  = 1'b0;
  logic [shr_pkg::TOTAL_W-1:0]    byte_sum     = '0;
  logic [shr_pkg::HANDLE_W-1:0]   restore_owed = '0;
  logic [shr_pkg::INTERVAL_W-1:0] interval_reg = shr_pkg::INTERVAL_RESET;
  logic [shr_pkg::LIMIT_W-1:0]    limit_reg    = shr_pkg::LIMIT_RESET;

  // Results the block still owes, oldest first.
  shr_pkg::rsp_t owed_results [$];

  int unsigned source_gap_pct = 7;
  int unsigned sink_gap_pct   = 77;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left   = 0;

  int requests_sent  = 0;
  int results_checked = 0;
  int longest_burst  = 0;
  int error_count    = 0;

  // Advance the predicted state by one accepted request and queue what it must produce.
  task automatic forecast_results(input logic [shr_pkg::ACTION_W-1:0] act,
                                  input logic [shr_pkg::HANDLE_W-1:0] h,
                                  input logic [shr_pkg::BYTES_W-1:0]  b,
                                  input logic                         ok);
    shr_pkg::rsp_t                  r;
    logic [shr_pkg::INTERVAL_W-1:0] ivl;
    logic [shr_pkg::LIMIT_W-1:0]    lim;
    logic [shr_pkg::IDX_W-1:0]      s;
    logic [shr_pkg::HANDLE_W-1:0]   freed [$];
    // A zero register behaves as one.
    ivl = (interval_reg == '0) ? shr_pkg::INTERVAL_W'(1) : interval_reg;
    lim = (limit_reg == '0) ? shr_pkg::LIMIT_W'(1) : limit_reg;
    r = '0;
    case (act)
      shr_pkg::ACT_CLEAR: begin
        // Walk back from the head, newest first; a pending restore survives the clear.
        s = ring_head;
        for (int i = 0; i < int'(ring_count); i++) begin
          s = (s == '0) ? shr_pkg::IDX_W'(shr_pkg::SLOTS - 1) : s - 1'b1;
          if (ring_full[s]) freed.push_back(ring_handle[s]);
          ring_full[s]   = 1'b0;
          ring_handle[s] = '0;
          ring_bytes[s]  = '0;
        end
        ring_head   = '0;
        ring_count  = '0;
        tick_count  = '0;
        fail_count  = '0;
        history_off = 1'b0;
        byte_sum    = '0;
      end
      shr_pkg::ACT_TICK: begin
        if (!history_off) begin
          tick_count = tick_count + 1'b1;
          if (tick_count >= ivl) begin
            tick_count = '0;
            r.capture_request = 1'b1;
          end
        end
      end
      shr_pkg::ACT_CAPTURE: begin
        if (!history_off) begin
          if (h == '0) begin
            // Failed capture: saturate the count, disable at the limit.
            if (fail_count != 8'hFF) fail_count = fail_count + 1'b1;
            if (fail_count >= lim) history_off = 1'b1;
          end else begin
            s = ring_head;
            fail_count = '0;
            if (ring_full[s]) begin
              // Overwrite the oldest entry and hand its handle back for freeing.
              byte_sum = byte_sum - ring_bytes[s];
              r.release_valid  = 1'b1;
              r.release_handle = ring_handle[s];
            end else begin
              ring_count = ring_count + 1'b1;
            end
            ring_full[s]   = 1'b1;
            ring_handle[s] = h;
            ring_bytes[s]  = b;
            ring_head = (s == shr_pkg::IDX_W'(shr_pkg::SLOTS - 1)) ? '0 : s + 1'b1;
            byte_sum  = byte_sum + b;
            r.accepted = 1'b1;
          end
        end
      end
      shr_pkg::ACT_REWIND: begin
        if (!history_off && ring_count != '0 && restore_owed == '0) begin
          // The head steps back even when the slot behind it turns out empty.
          s = (ring_head == '0) ? shr_pkg::IDX_W'(shr_pkg::SLOTS - 1) : ring_head - 1'b1;
          ring_head = s;
          if (ring_full[s]) begin
            r.accepted       = 1'b1;
            r.restore_valid  = 1'b1;
            r.restore_handle = ring_handle[s];
            byte_sum         = byte_sum - ring_bytes[s];
            ring_full[s]     = 1'b0;
            ring_handle[s]   = '0;
            ring_bytes[s]    = '0;
            ring_count       = ring_count - 1'b1;
            tick_count       = ivl - 1'b1;
            restore_owed     = r.restore_handle;
          end
        end
      end
      shr_pkg::ACT_RESTORE: begin
        if (restore_owed != '0) begin
          r.release_valid  = 1'b1;
          r.release_handle = restore_owed;
          restore_owed     = '0;
          if (ok) r.accepted = 1'b1;
          else history_off = 1'b1;
        end
      end
      default: ;
    endcase
    r.entries_held = ring_count;
    r.bytes_held   = byte_sum;
    r.disabled     = history_off;
    r.last         = 1'b1;
    if (act == shr_pkg::ACT_CLEAR && freed.size() != 0) begin
      // One release per held handle; only the final one carries last.
      foreach (freed[i]) begin
        r.release_valid  = 1'b1;
        r.release_handle = freed[i];
        r.last           = (i == freed.size() - 1);
        owed_results.push_back(r);
      end
      if (freed.size() > longest_burst) longest_burst = freed.size();
    end else begin
      owed_results.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------

  // Offer one request, idling first at random; valid stays high afterwards so that
  // back-to-back requests never lower and raise it in the same step.
  task automatic offer_request(input logic [shr_pkg::ACTION_W-1:0] act,
                               input logic [shr_pkg::HANDLE_W-1:0] h,
                               input logic [shr_pkg::BYTES_W-1:0]  b,
                               input logic                         ok);
    while ($urandom_range(99) < source_gap_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid          <= 1'b1;
    req_bus.action         <= act;
    req_bus.handle         <= h;
    req_bus.snapshot_bytes <= b;
    req_bus.restore_ok     <= ok;
    do @(posedge clk); while (!req_bus.ready);
    forecast_results(act, h, b, ok);
    requests_sent++;
  endtask

  // Drop valid and wait until every owed result has come back, then let the back end settle.
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register while nothing is in flight.
  task automatic program_register(input logic [shr_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [shr_pkg::CFG_DATA_W-1:0]  val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == shr_pkg::CFG_INTERVAL) interval_reg = val;
    else limit_reg = val[shr_pkg::LIMIT_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus an on-demand long hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (hold_ticket != hold_served) begin
        hold_served = hold_ticket;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= sink_gap_pct);
      end
    end
  end

  task automatic check_field(input string name, input word_t want, input word_t got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Compare every accepted result with the oldest owed one.
  always @(posedge clk) begin
    shr_pkg::rsp_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (owed_results.size() == 0) begin
        $error("result arrived while none was owed");
        error_count++;
      end else begin
        want = owed_results.pop_front();
        results_checked++;
        check_field("capture_request", word_t'(want.capture_request),
                    word_t'(rsp_bus.capture_request));
        check_field("accepted", word_t'(want.accepted), word_t'(rsp_bus.accepted));
        check_field("release_valid", word_t'(want.release_valid),
                    word_t'(rsp_bus.release_valid));
        check_field("release_handle", want.release_handle, rsp_bus.release_handle);
        check_field("restore_valid", word_t'(want.restore_valid),
                    word_t'(rsp_bus.restore_valid));
        check_field("restore_handle", want.restore_handle, rsp_bus.restore_handle);
        check_field("entries_held", word_t'(want.entries_held),
                    word_t'(rsp_bus.entries_held));
        check_field("bytes_held", word_t'(want.bytes_held), word_t'(rsp_bus.bytes_held));
        check_field("disabled", word_t'(want.disabled), word_t'(rsp_bus.disabled));
        check_field("last", word_t'(want.last), word_t'(rsp_bus.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Walk each action through its plain and corner behavior with small register values.
  task automatic test_directed_cases();
    program_register(shr_pkg::CFG_INTERVAL, 16'd2);
    program_register(shr_pkg::CFG_LIMIT, 16'd2);
    offer_request(shr_pkg::ACT_CLEAR, '0, '0, 1'b0);           // nothing held: one empty result
    for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
      offer_request(ACT_SPARE_FIRST + shr_pkg::ACTION_W'(a - ACT_SPARE_FIRST), '1, '1, 1'b1);
    offer_request(shr_pkg::ACT_RESTORE, '0, '0, 1'b1);         // no rewind before it
    offer_request(shr_pkg::ACT_REWIND, '0, '0, 1'b0);          // empty ring
    offer_request(shr_pkg::ACT_TICK, '0, '0, 1'b0);
    offer_request(shr_pkg::ACT_TICK, '0, '0, 1'b0);            // interval due
    offer_request(shr_pkg::ACT_CAPTURE, '1, '1, 1'b0);         // widest handle and size
    offer_request(shr_pkg::ACT_CAPTURE, 32'd1, '0, 1'b0);      // size unknown
    offer_request(shr_pkg::ACT_CAPTURE, '0, 24'h123456, 1'b1); // failed capture
    offer_request(shr_pkg::ACT_CAPTURE, 32'hA5A5_5A5A, 24'h80_0000, 1'b0);
    offer_request(shr_pkg::ACT_REWIND, '0, '0, 1'b0);
    offer_request(shr_pkg::ACT_REWIND, '0, '0, 1'b0);          // restore still pending
    offer_request(shr_pkg::ACT_RESTORE, '0, '0, 1'b1);
    offer_request(shr_pkg::ACT_REWIND, '0, '0, 1'b0);
    offer_request(shr_pkg::ACT_RESTORE, '0, '0, 1'b0);         // failed restore disables
    offer_request(shr_pkg::ACT_TICK, '0, '0, 1'b0);
    offer_request(shr_pkg::ACT_CAPTURE, 32'h0BAD_F00D, 24'h00_0010, 1'b0);
    offer_request(shr_pkg::ACT_REWIND, '0, '0, 1'b0);
    offer_request(shr_pkg::ACT_RESTORE, '0, '0, 1'b1);
    offer_request(shr_pkg::ACT_CLEAR, '0, '0, 1'b0);           // re-enable, free what is left
    offer_request(shr_pkg::ACT_CAPTURE, '0, '0, 1'b0);
    offer_request(shr_pkg::ACT_CAPTURE, '0, '0, 1'b0);         // limit of two reached
    offer_request(shr_pkg::ACT_CLEAR, '0, '0, 1'b0);
  endtask

  // Hit zero, one and full-scale register values.
  task automatic test_register_extremes();
    program_register(shr_pkg::CFG_INTERVAL, '0);
    program_register(shr_pkg::CFG_LIMIT, '0);
    offer_request(shr_pkg::ACT_TICK, '0, '0, 1'b0);
    offer_request(shr_pkg::ACT_TICK, '0, '0, 1'b0);
    offer_request(shr_pkg::ACT_CAPTURE, '0, '0, 1'b0);         // zero limit acts as one
    offer_request(shr_pkg::ACT_CLEAR, '0, '0, 1'b0);
    program_register(shr_pkg::CFG_INTERVAL, '1);
    offer_request(shr_pkg::ACT_CAPTURE, 32'h8000_0000, 24'hFF_FFFF, 1'b0);
    offer_request(shr_pkg::ACT_REWIND, '0, '0, 1'b0);          // rearm to interval minus one
    offer_request(shr_pkg::ACT_RESTORE, '0, '0, 1'b1);
    offer_request(shr_pkg::ACT_TICK, '0, '0, 1'b0);
    offer_request(shr_pkg::ACT_TICK, '0, '0, 1'b0);
    program_register(shr_pkg::CFG_INTERVAL, 16'd1);
    offer_request(shr_pkg::ACT_TICK, '0, '0, 1'b0);
    // Full-scale limit: one short of it keeps the history on, the next failure stops it.
    program_register(shr_pkg::CFG_LIMIT, shr_pkg::CFG_DATA_W'(8'hFF));
    repeat (254)
      offer_request(shr_pkg::ACT_CAPTURE, '0, shr_pkg::BYTES_W'($urandom), 1'b0);
    offer_request(shr_pkg::ACT_CAPTURE, '0, '0, 1'b0);
    offer_request(shr_pkg::ACT_CLEAR, '0, '0, 1'b0);
  endtask

  // Wrap the ring, pop a couple, refill it and clear it with every slot held.
  task automatic test_ring_wrap();
    offer_request(shr_pkg::ACT_CLEAR, '0, '0, 1'b0);
    for (int i = 0; i < shr_pkg::SLOTS + 4; i++)
      offer_request(shr_pkg::ACT_CAPTURE, shr_pkg::HANDLE_W'(32'h1000 + i),
                    ($urandom_range(3) == 0) ? '1 : shr_pkg::BYTES_W'($urandom), 1'b0);
    repeat (2) begin
      offer_request(shr_pkg::ACT_REWIND, '0, '0, 1'b0);
      offer_request(shr_pkg::ACT_RESTORE, '0, '0, 1'b1);
    end
    offer_request(shr_pkg::ACT_CAPTURE, 32'h2000, '1, 1'b0);
    offer_request(shr_pkg::ACT_CAPTURE, 32'h2001, '1, 1'b0);
    offer_request(shr_pkg::ACT_CLEAR, '0, '0, 1'b0);
  endtask

  // Stall the result side for a long stretch while requests keep coming.
  task automatic test_result_backpressure();
    hold_ticket <= hold_ticket + 1;
    offer_request(shr_pkg::ACT_CLEAR, '0, '0, 1'b0);
    repeat (24)
      offer_request(shr_pkg::ACT_CAPTURE,
                    shr_pkg::HANDLE_W'($urandom_range(1, 32'hFFFF_FFFF)),
                    shr_pkg::BYTES_W'($urandom), 1'b0);
    drain_results();
  endtask

  // Mostly well-formed traffic: ticks, captures, rewind/restore pairs, some noise.
  task automatic run_random_mix(input int count);
    int                           done;
    int                           pick;
    logic [shr_pkg::HANDLE_W-1:0] h;
    logic [shr_pkg::BYTES_W-1:0]  b;
    logic                         ok;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      h = $urandom;
      b = ($urandom_range(9) == 0) ? '1 : shr_pkg::BYTES_W'($urandom);
      ok = 1'($urandom_range(1));
      if (pick < 30) begin
        offer_request(shr_pkg::ACT_TICK, h, b, ok);
      end else if (pick < 62) begin
        if ($urandom_range(11) == 0) h = '0;
        else if (h == '0) h = 32'd1;
        offer_request(shr_pkg::ACT_CAPTURE, h, b, ok);
      end else if (pick < 82) begin
        offer_request(shr_pkg::ACT_REWIND, h, b, ok);
        if ($urandom_range(4) != 0) begin
          offer_request(shr_pkg::ACT_RESTORE, $urandom, b, $urandom_range(9) != 0);
          done++;
        end
      end else if (pick < 90) begin
        offer_request(shr_pkg::ACT_RESTORE, h, b, ok);
      end else if (pick < 94) begin
        offer_request(shr_pkg::ACT_CLEAR, h, b, ok);
      end else begin
        offer_request(shr_pkg::ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)),
                      h, b, ok);
        done--;
      end
      done++;
    end
  endtask

  // Three random phases: slow sink, slow source, then full speed on both sides.
  task automatic test_random_phases();
    program_register(shr_pkg::CFG_INTERVAL, 16'd3);
    program_register(shr_pkg::CFG_LIMIT, 16'd4);
    source_gap_pct = 7;
    sink_gap_pct   = 77;
    run_random_mix(RANDOM_PER_PHASE);
    program_register(shr_pkg::CFG_INTERVAL, 16'd1);
    program_register(shr_pkg::CFG_LIMIT, 16'd2);
    source_gap_pct = 77;
    sink_gap_pct   = 7;
    run_random_mix(RANDOM_PER_PHASE);
    program_register(shr_pkg::CFG_INTERVAL, 16'd5);
    program_register(shr_pkg::CFG_LIMIT, shr_pkg::CFG_DATA_W'(8'hFF));
    source_gap_pct = 0;
    sink_gap_pct   = 0;
    run_random_mix(RANDOM_PER_PHASE);
  endtask

  initial begin
    req_bus.valid          <= 1'b0;
    req_bus.action         <= shr_pkg::ACT_CLEAR;
    req_bus.handle         <= '0;
    req_bus.snapshot_bytes <= '0;
    req_bus.restore_ok     <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_index              <= shr_pkg::CFG_INTERVAL;
    cfg_data               <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_register_extremes();
    test_ring_wrap();
    test_result_backpressure();
    test_random_phases();
    drain_results();

    $display("Covered %0d requests and %0d results over all actions, zero and full-scale",
             requests_sent, results_checked);
    $display("registers, a %0d-handle clear burst and a %0d-cycle result stall.",
             longest_burst, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("snapshot_history_ring_tb OK");
    end else begin
      $display("snapshot_history_ring_tb NOT OK");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #1_000_000;
    $display("snapshot_history_ring_tb NOT OK");
    $finish;
  end

endmodule
